@@ design/zst_pkg.sv @@
// ----------------------------------------------------------------------------
// zst_pkg
// Shared types and constants of the Zhang-Suen thinning pass.
// ----------------------------------------------------------------------------
`default_nettype none

package zst_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int DIM_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;

   localparam int PIX_W   = 8;
   localparam int CFG_W   = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SUBPASS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic SUBPASS_FIRST  = 1'b0;
   localparam logic SUBPASS_SECOND = 1'b1;

   // Window taps, raster order: 0 1 2 / 3 4 5 / 6 7 8.
   typedef logic [8:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic interior;
      logic subpass;
   } decide_ctrl_type;

endpackage

`default_nettype wire

@@ design/zst_decide.sv @@
// ----------------------------------------------------------------------------
// zst_decide
// Deletion test of one Zhang-Suen subiteration on a 3x3 window.
// ----------------------------------------------------------------------------
`default_nettype none

module zst_decide (
   input  wire zst_pkg::window_type      window,
   input  wire zst_pkg::decide_ctrl_type ctrl,
   output logic                          delete_pixel
);

   logic [7:0] ring;
   logic [3:0] count;
   logic [3:0] trans;
   logic       p2, p4, p6, p8;
   logic       prod_ok;

   // Ring p2..p9 clockwise from the top neighbour.
   always_comb begin
      ring[0] = window[1] != '0;
      ring[1] = window[2] != '0;
      ring[2] = window[5] != '0;
      ring[3] = window[8] != '0;
      ring[4] = window[7] != '0;
      ring[5] = window[6] != '0;
      ring[6] = window[3] != '0;
      ring[7] = window[0] != '0;
   end

   always_comb begin
      count = '0;
      trans = '0;
      for (int k = 0; k < 8; k++) begin
         count = count + 4'(ring[k]);
         trans = trans + 4'(!ring[k] && ring[(k + 1) % 8]);
      end
   end

   assign p2 = ring[0];
   assign p4 = ring[2];
   assign p6 = ring[4];
   assign p8 = ring[6];

   always_comb begin
      if (ctrl.subpass == zst_pkg::SUBPASS_FIRST) begin
         prod_ok = !(p2 && p4 && p6) && !(p4 && p6 && p8);
      end else begin
         prod_ok = !(p2 && p4 && p8) && !(p2 && p6 && p8);
      end
   end

   assign delete_pixel = ctrl.interior && (window[4] != '0) && (count >= 4'd2) &&
                         (count <= 4'd6) && (trans == 4'd1) && prod_ok;

endmodule

`default_nettype wire

@@ design/zhang_suen_thinning_pass.sv @@
// ----------------------------------------------------------------------------
// zhang_suen_thinning_pass
// One Zhang-Suen thinning subiteration over a raster-ordered 8-bit frame,
// built from two line stores, a 3x3 window and a registered result word.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_op, req_pixel_in
//   rsp     | out       | rsp_valid / rsp_stall  | pixel_out, deleted, end_of_frame,
//           |           |                        | frame_changed
//   csr     | in        | csr_wr_en              | csr_index, csr_wdata
//
// One word is accepted per cycle while req_stall is low. A pixel passes from
// the line store read through one pipeline stage and then the result register.
// The result for a pixel appears one row plus one pixel of input later, and
// flush words drain the tail. Reset is synchronous; the line stores need no
// clearing. A stall on rsp holds the pipeline and stalls req in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module zhang_suen_thinning_pass (
   input  wire                               clock,
   input  wire                               reset,

   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire                               req_op,
   input  wire  [zst_pkg::PIX_W-1:0]         req_pixel_in,

   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [zst_pkg::PIX_W-1:0]         rsp_pixel_out,
   output logic                              rsp_deleted,
   output logic                              rsp_end_of_frame,
   output logic                              rsp_frame_changed,

   input  wire                               csr_wr_en,
   input  wire  [zst_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [zst_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int DW = zst_pkg::DIM_W;
   localparam int CW = zst_pkg::COL_W;
   localparam int RW = zst_pkg::ROW_W;
   localparam int PW = zst_pkg::PIX_W;

   // Configuration.
   logic                        subpass_ff;
   logic [zst_pkg::CFG_W-1:0]   width_ff;
   logic [zst_pkg::CFG_W-1:0]   height_ff;
   logic                        restart;

   logic [DW-1:0] eff_w;
   logic [DW-1:0] eff_h;

   // Input side counters.
   logic [CW-1:0] col_ff,   col_in;
   logic [RW-1:0] row_ff,   row_in;
   logic          done_ff,  done_in;
   logic [DW-1:0] flush_ff, flush_in;

   logic          accept;
   logic          push;
   logic          emit;
   logic          eof;
   logic [PW-1:0] pix;
   logic          col_last;

   // Read stage.
   logic          s1_valid_ff;
   logic          s1_emit_ff;
   logic          s1_eof_ff;
   logic [PW-1:0] s1_pix_ff;
   logic [CW-1:0] s1_col_ff;
   logic [PW-1:0] rd_up_ff;
   logic [PW-1:0] rd_mid_ff;
   logic          s1_adv;
   logic          out_free;

   logic [PW-1:0] upper_mem  [zst_pkg::MAX_WIDTH];
   logic [PW-1:0] middle_mem [zst_pkg::MAX_WIDTH];

   // Window and output side counters.
   zst_pkg::window_type      window_ff, window_in;
   zst_pkg::decide_ctrl_type ctrl;
   logic                     del;
   logic [CW-1:0]            ocol_ff;
   logic [RW-1:0]            orow_ff;
   logic                     changed_ff;

   // Result register.
   logic          rsp_valid_ff;
   logic [PW-1:0] rsp_pixel_ff;
   logic          rsp_deleted_ff;
   logic          rsp_eof_ff;
   logic          rsp_changed_ff;

   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         subpass_ff <= 1'b0;
         width_ff   <= zst_pkg::WIDTH_RESET;
         height_ff  <= zst_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            zst_pkg::CSR_SUBPASS:      subpass_ff <= csr_wdata[0];
            zst_pkg::CSR_FRAME_WIDTH:  width_ff   <= csr_wdata;
            zst_pkg::CSR_FRAME_HEIGHT: height_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign restart = csr_wr_en && ((csr_index == zst_pkg::CSR_FRAME_WIDTH) ||
                                  (csr_index == zst_pkg::CSR_FRAME_HEIGHT));

   always_comb begin
      eff_w = DW'(width_ff);
      if (eff_w < DW'(3)) begin
         eff_w = DW'(3);
      end else if (eff_w > DW'(zst_pkg::MAX_WIDTH)) begin
         eff_w = DW'(zst_pkg::MAX_WIDTH);
      end
      eff_h = DW'(height_ff);
      if (eff_h < DW'(3)) begin
         eff_h = DW'(3);
      end else if (eff_h > DW'(zst_pkg::MAX_HEIGHT)) begin
         eff_h = DW'(zst_pkg::MAX_HEIGHT);
      end
   end

   // ------------------------------------------------------------------------
   // Input side: classify the word and advance the raster counters.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;
   assign col_last  = DW'(col_ff) == eff_w - DW'(1);

   always_comb begin
      push = 1'b0;
      emit = 1'b0;
      eof  = 1'b0;
      pix  = '0;
      if (done_ff) begin
         push = 1'b1;
         emit = 1'b1;
         eof  = flush_ff == eff_w;
      end else if (req_op == zst_pkg::OP_PIXEL) begin
         push = 1'b1;
         pix  = req_pixel_in;
         emit = (row_ff >= RW'(2)) || ((row_ff == RW'(1)) && (col_ff != '0));
      end
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      done_in  = done_ff;
      flush_in = flush_ff;
      if (restart) begin
         col_in   = '0;
         row_in   = '0;
         done_in  = 1'b0;
         flush_in = '0;
      end else if (accept && push) begin
         if (eof) begin
            col_in   = '0;
            row_in   = '0;
            done_in  = 1'b0;
            flush_in = '0;
         end else begin
            col_in = col_last ? '0 : col_ff + CW'(1);
            if (done_ff) begin
               flush_in = flush_ff + DW'(1);
            end else if (col_last) begin
               if (DW'(row_ff) == eff_h - DW'(1)) begin
                  done_in = 1'b1;
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         done_ff  <= 1'b0;
         flush_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         done_ff  <= done_in;
         flush_ff <= flush_in;
      end
   end

   // ------------------------------------------------------------------------
   // Read stage and line stores.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept && push) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && push) begin
         s1_emit_ff <= emit;
         s1_eof_ff  <= eof;
         s1_pix_ff  <= pix;
         s1_col_ff  <= col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && push) begin
         rd_up_ff <= upper_mem[col_ff];
      end
      if (s1_adv) begin
         upper_mem[s1_col_ff] <= rd_mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && push) begin
         rd_mid_ff <= middle_mem[col_ff];
      end
      if (s1_adv) begin
         middle_mem[s1_col_ff] <= s1_pix_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Window shift and decision.
   always_comb begin
      window_in    = window_ff;
      window_in[0] = window_ff[1];
      window_in[1] = window_ff[2];
      window_in[3] = window_ff[4];
      window_in[4] = window_ff[5];
      window_in[6] = window_ff[7];
      window_in[7] = window_ff[8];
      window_in[2] = rd_up_ff;
      window_in[5] = rd_mid_ff;
      window_in[8] = s1_pix_ff;
   end

   always_comb begin
      ctrl.subpass  = subpass_ff;
      ctrl.interior = (orow_ff != '0) && (DW'(orow_ff) != eff_h - DW'(1)) &&
                      (ocol_ff != '0) && (DW'(ocol_ff) != eff_w - DW'(1));
   end

   zst_decide u_decide (
      .window       (window_in),
      .ctrl         (ctrl),
      .delete_pixel (del)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_adv) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         ocol_ff    <= '0;
         orow_ff    <= '0;
         changed_ff <= 1'b0;
      end else if (s1_adv && s1_emit_ff) begin
         if (s1_eof_ff) begin
            ocol_ff    <= '0;
            orow_ff    <= '0;
            changed_ff <= 1'b0;
         end else begin
            if (DW'(ocol_ff) == eff_w - DW'(1)) begin
               ocol_ff <= '0;
               orow_ff <= orow_ff + RW'(1);
            end else begin
               ocol_ff <= ocol_ff + CW'(1);
            end
            changed_ff <= changed_ff || del;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         rsp_pixel_ff   <= del ? '0 : window_in[4];
         rsp_deleted_ff <= del;
         rsp_eof_ff     <= s1_eof_ff;
         rsp_changed_ff <= s1_eof_ff && (changed_ff || del);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_out     = rsp_pixel_ff;
   assign rsp_deleted       = rsp_deleted_ff;
   assign rsp_end_of_frame  = rsp_eof_ff;
   assign rsp_frame_changed = rsp_changed_ff;

   // ------------------------------------------------------------------------
   a_deleted_is_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_deleted_ff) |-> (rsp_pixel_ff == '0))
      else $error("A deleted pixel left with a nonzero value.");

   a_changed_at_eof : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_changed_ff) |-> rsp_eof_ff)
      else $error("The frame change flag was raised away from the frame end.");

   a_flush_emits : assert property (@(posedge clock) disable iff (reset)
      (accept && done_ff && !restart) |=> (s1_valid_ff && s1_emit_ff))
      else $error("A draining word did not produce a result.");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("The read stage lost a held word.");

   a_change_sticks : assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_emit_ff && del && !s1_eof_ff && !restart) |=> changed_ff)
      else $error("A deletion was not recorded for the frame.");

endmodule

`default_nettype wire
